// File: rtl/pal_pkg.sv
// Shared types for the positional array list: request codes, sequencer states, status flags.
package pal_pkg;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_LOCATE = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } pal_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CAP,
    ST_SCAN,
    ST_SHUP,
    ST_INSWR,
    ST_SHDN,
    ST_DONE
  } pal_state_t;

  typedef struct packed {
    logic ok;
    logic empty;
  } pal_status_t;

endpackage

// File: rtl/pal_if.sv
// Request and response channel interfaces for the positional array list.
interface pal_req_if #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32
);
  localparam int POS_W = $clog2(DEPTH + 2);

  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [POS_W-1:0]             position;
  logic signed [VALUE_BITS-1:0] item_value;

  modport source (output valid, output req_type, output position, output item_value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input item_value,
                  output ready);
endinterface

interface pal_rsp_if #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32
);
  localparam int POS_W = $clog2(DEPTH + 2);

  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic signed [VALUE_BITS-1:0] out_value;
  logic [POS_W-1:0]             found_position;
  logic [POS_W-1:0]             list_length;
  logic                         list_empty;

  modport source (output valid, output ok, output out_value, output found_position,
                  output list_length, output list_empty, input ready);
  modport sink   (input valid, input ok, input out_value, input found_position,
                  input list_length, input list_empty, output ready);
endinterface

// File: rtl/pal_core.sv
// Element memory and the sequencer that walks it for get, locate, insert and delete.
module pal_core
  import pal_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32,
  parameter int POS_W      = $clog2(DEPTH + 2),
  parameter int ADDR_W     = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [1:0]            req_type,
  input  logic [POS_W-1:0]      req_pos,
  input  logic [VALUE_BITS-1:0] req_value,
  output logic                  res_valid,
  input  logic                  res_ready,
  output pal_status_t           res_status,
  output logic [VALUE_BITS-1:0] res_value,
  output logic [POS_W-1:0]      res_found,
  output logic [POS_W-1:0]      res_len
);

  localparam logic [POS_W-1:0] DEPTH_C = POS_W'(DEPTH);
  localparam logic [POS_W-1:0] ONE_C   = POS_W'(1);

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_data_r;

  pal_state_t            state_r, state_nxt;
  pal_op_t               op_r, op_nxt, op_in;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [POS_W-1:0]      cnt_r, cnt_nxt;
  logic [POS_W-1:0]      idx_r, idx_nxt;
  logic                  p_vld_r, p_vld_nxt;
  logic [ADDR_W-1:0]     p_dst_r, p_dst_nxt;
  logic                  res_ok_r, res_ok_nxt;
  logic [VALUE_BITS-1:0] res_val_r, res_val_nxt;
  logic [POS_W-1:0]      res_found_r, res_found_nxt;

  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [VALUE_BITS-1:0] mem_wdata;

  logic accept, pos_ok_rd, pos_ok_ins, hit, scan_last, up_more, dn_more, scan_rd;

  assign op_in      = pal_op_t'(req_type);
  assign accept     = req_valid && req_ready;
  assign pos_ok_rd  = (req_pos != '0) && (req_pos <= cnt_r);
  assign pos_ok_ins = (req_pos != '0) && (req_pos <= cnt_r + ONE_C) && (cnt_r < DEPTH_C);
  assign hit        = (rd_data_r == val_r);
  assign scan_last  = (p_dst_r == ADDR_W'(cnt_r - ONE_C));
  assign scan_rd    = (idx_r < cnt_r);
  // insert moves entries top-down: read idx-1, write idx; delete bottom-up: read idx+1, write idx
  assign up_more    = (idx_r >= pos_r);
  assign dn_more    = ((idx_r + ONE_C) < cnt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          case (op_in)
            OP_GET:    state_nxt = pos_ok_rd ? ST_RD : ST_DONE;
            OP_LOCATE: state_nxt = (cnt_r == '0) ? ST_DONE : ST_SCAN;
            OP_INSERT: state_nxt = pos_ok_ins ? ST_SHUP : ST_DONE;
            OP_DELETE: state_nxt = pos_ok_rd ? ST_RD : ST_DONE;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_RD:    state_nxt = ST_CAP;
      ST_CAP:   state_nxt = (op_r == OP_DELETE) ? ST_SHDN : ST_DONE;
      ST_SCAN:  if (p_vld_r && (hit || scan_last)) state_nxt = ST_DONE;
      ST_SHUP:  if (!up_more) state_nxt = ST_INSWR;
      ST_INSWR: state_nxt = ST_DONE;
      ST_SHDN:  if (!dn_more) state_nxt = ST_DONE;
      ST_DONE:  if (res_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // memory control and handshake outputs
  always_comb begin
    req_ready = (state_r == ST_IDLE);
    res_valid = (state_r == ST_DONE);
    mem_we    = 1'b0;
    mem_waddr = p_dst_r;
    mem_wdata = rd_data_r;
    mem_re    = 1'b0;
    mem_raddr = idx_r[ADDR_W-1:0];
    case (state_r)
      ST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ADDR_W'(pos_r - ONE_C);
      end
      ST_SCAN: begin
        mem_re = scan_rd;
      end
      ST_SHUP: begin
        mem_we    = p_vld_r;
        mem_re    = up_more;
        mem_raddr = ADDR_W'(idx_r - ONE_C);
      end
      ST_INSWR: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(pos_r - ONE_C);
        mem_wdata = val_r;
      end
      ST_SHDN: begin
        mem_we    = p_vld_r;
        mem_re    = dn_more;
        mem_raddr = ADDR_W'(idx_r + ONE_C);
      end
      default: ;
    endcase
  end

  // length after the request
  always_comb begin
    res_len = cnt_r;
    if (res_ok_r && (op_r == OP_INSERT)) res_len = cnt_r + ONE_C;
    if (res_ok_r && (op_r == OP_DELETE)) res_len = cnt_r - ONE_C;
  end

  assign res_status.ok    = res_ok_r;
  assign res_status.empty = (res_len == '0);
  assign res_value        = res_val_r;
  assign res_found        = res_found_r;

  // datapath next values
  always_comb begin
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    p_vld_nxt     = p_vld_r;
    p_dst_nxt     = p_dst_r;
    res_ok_nxt    = res_ok_r;
    res_val_nxt   = res_val_r;
    res_found_nxt = res_found_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt        = op_in;
          pos_nxt       = req_pos;
          val_nxt       = req_value;
          p_vld_nxt     = 1'b0;
          res_val_nxt   = '0;
          res_found_nxt = '0;
          case (op_in)
            OP_LOCATE: begin
              res_ok_nxt = 1'b1;
              idx_nxt    = '0;
            end
            OP_INSERT: begin
              res_ok_nxt = pos_ok_ins;
              idx_nxt    = cnt_r;
            end
            OP_DELETE: begin
              res_ok_nxt = pos_ok_rd;
              idx_nxt    = req_pos - ONE_C;
            end
            default: begin
              res_ok_nxt = pos_ok_rd;
              idx_nxt    = '0;
            end
          endcase
        end
      end
      ST_CAP: res_val_nxt = rd_data_r;
      ST_SCAN: begin
        p_vld_nxt = scan_rd;
        p_dst_nxt = idx_r[ADDR_W-1:0];
        if (scan_rd) idx_nxt = idx_r + ONE_C;
        if (p_vld_r && hit) res_found_nxt = POS_W'(p_dst_r) + ONE_C;
      end
      ST_SHUP: begin
        p_vld_nxt = up_more;
        p_dst_nxt = idx_r[ADDR_W-1:0];
        if (up_more) idx_nxt = idx_r - ONE_C;
      end
      ST_SHDN: begin
        p_vld_nxt = dn_more;
        p_dst_nxt = idx_r[ADDR_W-1:0];
        if (dn_more) idx_nxt = idx_r + ONE_C;
      end
      ST_DONE: if (res_ready) cnt_nxt = res_len;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      p_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      p_vld_r <= p_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    idx_r       <= idx_nxt;
    p_dst_r     <= p_dst_nxt;
    res_ok_r    <= res_ok_nxt;
    res_val_r   <= res_val_nxt;
    res_found_r <= res_found_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("element count above depth");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_SHUP || state_r == ST_INSWR || state_r == ST_SHDN))
    else $error("memory write outside an insert or delete");

  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && res_ready) |=> (state_r == ST_IDLE))
    else $error("sequencer did not return to idle after result");

  a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(cnt_r) |-> $past(state_r == ST_DONE && res_ok_r))
    else $error("count changed outside a successful completion");
`endif

endmodule

// File: rtl/positional_array_list.sv
// Top level of the positional array list: element memory sequencer plus output register.
// Holds an ordered list of up to DEPTH words in one single-port-read, single-port-write
// memory and processes one transaction at a time. Get reads and captures the entry at the
// position; locate examines entries in order up to the list length until the first hit; a
// rejected request or a locate on an empty list goes straight to the result; insert shifts
// the entries from the tail down to position p up by one, then writes the new word; delete
// captures the entry at p and shifts the entries above it down by one. The element memory
// moves one entry per cycle through its read port, the write port trailing it by a register.
// A new request is taken when the sequencer is idle, even while a result still waits in the
// output register. Memory contents need no clearing after reset; the list starts empty.
module positional_array_list
  import pal_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  pal_req_if.sink   in_req,
  pal_rsp_if.source out_rsp
);

  localparam int POS_W = $clog2(DEPTH + 2);

  logic                  res_valid, res_ready;
  pal_status_t           res_status;
  logic [VALUE_BITS-1:0] res_value;
  logic [POS_W-1:0]      res_found, res_len;

  logic                  out_valid_r;
  logic                  out_ok_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic [POS_W-1:0]      out_found_r, out_len_r;
  logic                  out_empty_r;

  pal_core #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_req.valid),
    .req_ready  (in_req.ready),
    .req_type   (in_req.req_type),
    .req_pos    (in_req.position),
    .req_value  (in_req.item_value),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_status (res_status),
    .res_value  (res_value),
    .res_found  (res_found),
    .res_len    (res_len)
  );

  assign res_ready = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_ok_r    <= res_status.ok;
      out_value_r <= res_value;
      out_found_r <= res_found;
      out_len_r   <= res_len;
      out_empty_r <= res_status.empty;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.ok             = out_ok_r;
  assign out_rsp.out_value      = out_value_r;
  assign out_rsp.found_position = out_found_r;
  assign out_rsp.list_length    = out_len_r;
  assign out_rsp.list_empty     = out_empty_r;

endmodule

// File: tb/tb_positional_array_list.sv
// Self-checking testbench for positional_array_list: list-op traffic scored against a shadow list.
module tb_positional_array_list;
  import pal_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 32;
  localparam int POS_W      = $clog2(DEPTH + 2);
  localparam int RAND_ITEMS = 1700;
  localparam int HOLD_AT    = 1300;
  localparam int HOLD_CYC   = 300;
  localparam int TAIL_CYC   = 80;

  typedef struct {
    pal_op_t                      op;
    logic [POS_W-1:0]             pos;
    logic signed [VALUE_BITS-1:0] val;
    bit                           drain;
    int                           phase;
  } list_req_t;

  typedef struct packed {
    logic                         ok;
    logic signed [VALUE_BITS-1:0] value;
    logic [POS_W-1:0]             found;
    logic [POS_W-1:0]             length;
    logic                         empty;
  } list_rsp_t;

  logic clk;
  logic rst_n;

  pal_req_if #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) in_req ();
  pal_rsp_if #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) out_rsp ();

  positional_array_list #(
    .DEPTH     (DEPTH),
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  // shadow copy of the list
  logic signed [VALUE_BITS-1:0] list_mem [DEPTH];
  int                           list_len;

  list_req_t pending_reqs[$];
  list_rsp_t expected_rsps[$];
  list_req_t cur_req;
  int        gen_len;
  int        req_done;
  int        n_reqs;
  int        mismatches;
  int        rx_phase;
  bit        rx_hold;

  // sender / receiver idle percentages per traffic phase
  int tx_idle_pct[3] = '{20, 57, 0};
  int rx_idle_pct[3] = '{57, 20, 0};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic list_rsp_t apply_request(list_req_t r);
    list_rsp_t e;
    int        p;
    e = '0;
    p = r.pos;
    case (r.op)
      OP_GET: begin
        if (p >= 1 && p <= list_len) begin
          e.ok    = 1'b1;
          e.value = list_mem[p-1];
        end
      end
      OP_LOCATE: begin
        e.ok = 1'b1;
        for (int j = 0; j < list_len; j++)
          if (e.found == 0 && list_mem[j] == r.val) e.found = POS_W'(j + 1);
      end
      OP_INSERT: begin
        if (p >= 1 && p <= list_len + 1 && list_len < DEPTH) begin
          for (int j = list_len; j > p - 1; j--) list_mem[j] = list_mem[j-1];
          list_mem[p-1] = r.val;
          list_len++;
          e.ok = 1'b1;
        end
      end
      default: begin
        if (p >= 1 && p <= list_len) begin
          e.value = list_mem[p-1];
          for (int j = p - 1; j + 1 < list_len; j++) list_mem[j] = list_mem[j+1];
          list_len--;
          e.ok = 1'b1;
        end
      end
    endcase
    e.length = POS_W'(list_len);
    e.empty  = (list_len == 0);
    return e;
  endfunction

  // queue a request, tracking the list length the generator expects
  function automatic void add_req(pal_op_t op, int pos, logic signed [VALUE_BITS-1:0] val,
                                  int phase, bit drain);
    list_req_t r;
    r.op    = op;
    r.pos   = POS_W'(pos);
    r.val   = val;
    r.phase = phase;
    r.drain = drain;
    pending_reqs.push_back(r);
    if (op == OP_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < DEPTH) gen_len++;
    if (op == OP_DELETE && pos >= 1 && pos <= gen_len) gen_len--;
  endfunction

  // small pool so locates hit often, plus extremes and full-width noise
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    logic signed [VALUE_BITS-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = $urandom_range(7);
      5:             v = 0 - $urandom_range(1, 4);
      6:             v = $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default:       v = $urandom();
    endcase
    return v;
  endfunction

  function automatic int pick_pos(pal_op_t op);
    int hi;
    hi = (op == OP_INSERT) ? gen_len + 1 : gen_len;
    if (op == OP_LOCATE) return $urandom_range(DEPTH + 1);
    if ($urandom_range(99) < 85 && hi >= 1) return $urandom_range(1, hi);
    case ($urandom_range(4))
      0:       return 0;
      1:       return hi + 1;
      2:       return DEPTH;
      3:       return DEPTH + 1;
      default: return $urandom_range(DEPTH + 1);
    endcase
  endfunction

  task automatic build_stimulus();
    bit      grow;
    int      roll;
    int      phase;
    pal_op_t op;
    // empty-list corner cases and bad positions
    add_req(OP_GET,    1, 0, 0, 0);
    add_req(OP_DELETE, 1, 0, 0, 0);
    add_req(OP_LOCATE, 0, 0, 0, 0);
    add_req(OP_INSERT, 0, 5, 0, 0);
    add_req(OP_INSERT, 2, 5, 0, 0);
    // insert at end, front and middle with extreme values
    add_req(OP_INSERT, 1, 32'sh7fff_ffff, 0, 0);
    add_req(OP_INSERT, 2, 32'sh8000_0000, 0, 0);
    add_req(OP_INSERT, 1, -1, 0, 0);
    add_req(OP_INSERT, 2, 0, 0, 0);
    add_req(OP_INSERT, 5, 0, 0, 0);
    add_req(OP_GET,    0, 0, 0, 0);
    add_req(OP_GET,    4, 0, 0, 0);
    add_req(OP_GET,    6, 0, 0, 0);
    add_req(OP_LOCATE, 9, 32'sh8000_0000, 0, 0);
    add_req(OP_LOCATE, 0, 0, 0, 0);
    add_req(OP_LOCATE, 0, 12345, 0, 0);
    add_req(OP_LOCATE, 0, -1, 0, 0);
    add_req(OP_INSERT, DEPTH + 1, 1, 0, 0);
    add_req(OP_DELETE, 6, 0, 0, 0);
    add_req(OP_DELETE, 0, 0, 0, 0);
    add_req(OP_DELETE, 1, 0, 0, 0);
    add_req(OP_DELETE, 3, 0, 0, 0);
    add_req(OP_GET,    DEPTH, 0, 0, 0);
    add_req(OP_INSERT, DEPTH, 0, 0, 0);
    add_req(OP_DELETE, 1, 0, 0, 0);

    // random walk: grow to full, shrink to empty, with reads and bad positions mixed in
    grow = 1'b1;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      phase = (i < RAND_ITEMS / 3) ? 0 : (i < 2 * RAND_ITEMS / 3) ? 1 : 2;
      if (gen_len == DEPTH && $urandom_range(3) == 0) grow = 1'b0;
      if (gen_len == 0) grow = 1'b1;
      if ($urandom_range(79) == 0) grow = ~grow;
      roll = $urandom_range(99);
      if (roll < 45)      op = grow ? OP_INSERT : OP_DELETE;
      else if (roll < 60) op = grow ? OP_DELETE : OP_INSERT;
      else if (roll < 80) op = OP_GET;
      else                op = OP_LOCATE;
      add_req(op, pick_pos(op), pick_value(), phase, (i == 0) || ($urandom_range(99) == 0));
    end
  endtask

  // driver: one transaction offered at a time from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        expected_rsps.push_back(apply_request(cur_req));
        req_done++;
      end
      if (!in_req.valid || in_req.ready) begin
        if (pending_reqs.size() != 0 &&
            !(pending_reqs[0].drain && expected_rsps.size() != 0) &&
            $urandom_range(99) >= tx_idle_pct[pending_reqs[0].phase]) begin
          cur_req = pending_reqs.pop_front();
          rx_phase <= cur_req.phase;
          in_req.valid      <= 1'b1;
          in_req.req_type   <= cur_req.op;
          in_req.position   <= cur_req.pos;
          in_req.item_value <= cur_req.val;
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: score each accepted result against the oldest expectation
  always @(posedge clk) begin
    list_rsp_t got;
    list_rsp_t exp_rsp;
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        got = {out_rsp.ok, out_rsp.out_value, out_rsp.found_position,
               out_rsp.list_length, out_rsp.list_empty};
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result ok=%0b value=%0d found=%0d len=%0d empty=%0b",
                     $realtime, got.ok, got.value, got.found, got.length, got.empty);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (got !== exp_rsp) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("%0t: mismatch exp ok=%0b value=%0d found=%0d len=%0d empty=%0b",
                     $realtime, exp_rsp.ok, exp_rsp.value, exp_rsp.found, exp_rsp.length,
                     exp_rsp.empty);
              $display(" | got ok=%0b value=%0d found=%0d len=%0d empty=%0b",
                       got.ok, got.value, got.found, got.length, got.empty);
            end
          end
        end
      end
      out_rsp.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct[rx_phase]);
    end
  end

  // long receiver stall while the sender keeps offering
  initial begin
    rx_hold = 1'b0;
    wait (req_done >= HOLD_AT);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #20ms;
    $display("** positional_array_list: FAILED **");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    in_req.valid       = 1'b0;
    in_req.req_type    = OP_GET;
    in_req.position    = '0;
    in_req.item_value  = '0;
    out_rsp.ready      = 1'b0;
    list_len           = 0;
    gen_len            = 0;
    req_done           = 0;
    mismatches         = 0;
    rx_phase           = 0;
    build_stimulus();
    n_reqs             = pending_reqs.size();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (req_done < n_reqs || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("** positional_array_list: PASSED **");
    end else begin
      $display("** positional_array_list: FAILED **");
    end
    $finish;
  end

endmodule
